FILE: hw/rtl/rv64eu_pkg.sv
// shared types, opcodes, trap causes and reset values for the rv64i execute unit
package rv64eu_pkg;

  localparam int unsigned CSR_ENTRIES_DFLT = 4096;

  // input item
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] instruction;
    logic [63:0] mem_data;
    logic        mem_fault;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [63:0] fetch_pc;
    logic [1:0]  mem_request;
    logic [63:0] mem_address;
    logic [1:0]  mem_size;
    logic [63:0] store_data;
    logic        trap_taken;
    logic [2:0]  trap_cause;
    logic        ecall_request;
    logic [63:0] syscall_number;
  } out_item_t;

  // item kinds
  localparam logic [1:0] KIND_INSN        = 2'd0;
  localparam logic [1:0] KIND_LOAD_RSP    = 2'd1;
  localparam logic [1:0] KIND_STORE_RSP   = 2'd2;
  localparam logic [1:0] KIND_FETCH_FAULT = 2'd3;

  // memory request codes, also used for the pending access
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_STORE = 2'd2;

  // mcause codes
  localparam logic [2:0] CAUSE_INSN_MISALIGNED = 3'd0;
  localparam logic [2:0] CAUSE_FETCH_FAULT     = 3'd1;
  localparam logic [2:0] CAUSE_ILLEGAL         = 3'd2;
  localparam logic [2:0] CAUSE_BREAKPOINT      = 3'd3;
  localparam logic [2:0] CAUSE_LOAD_FAULT      = 3'd5;
  localparam logic [2:0] CAUSE_STORE_FAULT     = 3'd7;

  // major opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP32   = 7'h3B;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  // system immediates
  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;
  localparam logic [11:0] SYS_MRET   = 12'h302;

  // trap csr addresses
  localparam int unsigned CSR_MSTATUS = 'h300;
  localparam int unsigned CSR_MTVEC   = 'h305;
  localparam int unsigned CSR_MEPC    = 'h341;
  localparam int unsigned CSR_MCAUSE  = 'h342;
  localparam int unsigned CSR_MTVAL   = 'h343;

  // configuration register indexes
  localparam logic CFG_START_PC = 1'b0;
  localparam logic CFG_SP_INIT  = 1'b1;

  // reset values
  localparam logic [63:0] START_PC_RST = 64'd0;
  localparam logic [63:0] SP_INIT_RST  = 64'd4194296;

  // register holding the syscall number
  localparam logic [4:0] REG_SYSCALL = 5'd17;
  localparam logic [4:0] REG_SP      = 5'd2;

endpackage

FILE: hw/rtl/rv64i_execute_unit_top.sv
// rv64i execute unit: register file and csr store in memories, read-modify-write core
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_valid / in_ready   | in_data   (kind, instruction, mem_data, mem_fault)
//  out_    | out | out_valid / out_ready | out_data  (fetch_pc .. syscall_number)
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle while the output is not stalled; each result passes a memory read
// stage, then an execute stage with forwarding of the last write, into the output register
// after reset the csr memory is cleared entry by entry; in_ready stays low during that pass
// a stalled output holds the execute stage, and in_ready drops in the same cycle
// CSR_ENTRIES must be a power of two; the block itself does not check it
module rv64i_execute_unit_top #(
  parameter int unsigned CSR_ENTRIES = rv64eu_pkg::CSR_ENTRIES_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rv64eu_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rv64eu_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [63:0]           cfg_data
);
  import rv64eu_pkg::*;

  localparam int unsigned CI_W = $clog2(CSR_ENTRIES);
  localparam logic [CI_W-1:0] IDX_MSTATUS = CI_W'(CSR_MSTATUS % CSR_ENTRIES);
  localparam logic [CI_W-1:0] IDX_MTVEC   = CI_W'(CSR_MTVEC % CSR_ENTRIES);
  localparam logic [CI_W-1:0] IDX_MEPC    = CI_W'(CSR_MEPC % CSR_ENTRIES);
  localparam logic [CI_W-1:0] IDX_MCAUSE  = CI_W'(CSR_MCAUSE % CSR_ENTRIES);
  localparam logic [CI_W-1:0] IDX_MTVAL   = CI_W'(CSR_MTVAL % CSR_ENTRIES);
  localparam logic [CI_W-1:0] IDX_LAST    = CI_W'(CSR_ENTRIES - 1);

  // control and architectural flops
  logic            s1_valid_r;
  in_item_t        s1_r;
  logic            out_valid_r;
  out_item_t       out_r;
  logic [63:0]     pc_r, pc_nxt;
  logic [63:0]     sp_init_r;
  logic [31:0]     rf_vld_r;
  logic [1:0]      pend_kind_r, pend_kind_nxt;
  logic [4:0]      pend_dest_r, pend_dest_nxt;
  logic [2:0]      pend_sz_r, pend_sz_nxt;
  logic [63:0]     pend_addr_r, pend_addr_nxt;
  logic [63:0]     mstatus_r, mtvec_r, mepc_r, mcause_r, mtval_r;
  logic            clr_active_r;
  logic [CI_W-1:0] clr_cnt_r;

  // forwarding of the last memory writes
  logic            rf_fwd_vld_r;
  logic [4:0]      rf_fwd_addr_r;
  logic [63:0]     rf_fwd_data_r;
  logic            csr_fwd_vld_r;
  logic [CI_W-1:0] csr_fwd_idx_r;
  logic [63:0]     csr_fwd_data_r;

  // memories
  logic [63:0]     rf_mem [32];
  logic [63:0]     csr_mem [CSR_ENTRIES];
  logic [63:0]     rf_rdata_a_r, rf_rdata_b_r, csr_rdata_r;

  logic            s1_adv, s1_hold, in_xfer, cfg_xfer;
  logic [31:0]     rd_ins;
  logic [4:0]      rf_ra, rf_rb;
  logic [CI_W-1:0] csr_ra;

  // execute stage signals
  logic [31:0]     ins;
  logic [6:0]      op;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [4:0]      rd, rs1, rb_sel;
  logic [CI_W-1:0] ca_idx;
  logic [63:0]     opa, opb, csr_old;
  logic            ca_special;
  out_item_t       res;
  logic            rf_we;
  logic [4:0]      rf_wa;
  logic [63:0]     rf_wd;
  logic            csr_wr;
  logic [63:0]     csr_new;
  logic            trap_en, mret_en;
  logic [2:0]      trap_code;
  logic [63:0]     trap_val;
  logic            csr_mem_we;
  logic [CI_W-1:0] csr_mem_wa;
  logic [63:0]     csr_mem_wd;

  // handshakes
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_hold   = s1_valid_r && !s1_adv;
  assign in_ready  = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // read addresses follow the held item or the incoming one
  assign rd_ins = s1_hold ? s1_r.instruction : in_data.instruction;
  assign rf_ra  = rd_ins[19:15];
  assign rf_rb  = (rd_ins[6:0] == OPC_SYSTEM && rd_ins[14:12] == 3'd0) ? REG_SYSCALL
                                                                       : rd_ins[24:20];
  assign csr_ra = rd_ins[20 +: CI_W];

  // register file memory
  always_ff @(posedge clk) begin
    if (rf_we && s1_adv) rf_mem[rf_wa] <= rf_wd;
    rf_rdata_a_r <= rf_mem[rf_ra];
    rf_rdata_b_r <= rf_mem[rf_rb];
  end

  // csr memory, also swept to zero after reset
  assign csr_mem_we = clr_active_r || (s1_adv && csr_wr && !trap_en && !ca_special);
  assign csr_mem_wa = clr_active_r ? clr_cnt_r : ca_idx;
  assign csr_mem_wd = clr_active_r ? 64'd0 : csr_new;

  always_ff @(posedge clk) begin
    if (csr_mem_we) csr_mem[csr_mem_wa] <= csr_mem_wd;
    csr_rdata_r <= csr_mem[csr_ra];
  end

  // decode of the item in execute
  assign ins     = s1_r.instruction;
  assign op      = ins[6:0];
  assign f3      = ins[14:12];
  assign f7      = ins[31:25];
  assign rd      = ins[11:7];
  assign rs1     = ins[19:15];
  assign rb_sel  = (op == OPC_SYSTEM && f3 == 3'd0) ? REG_SYSCALL : ins[24:20];
  assign ca_idx  = ins[20 +: CI_W];

  // register read with forwarding and reset values for unwritten entries
  always_comb begin
    if (rs1 == 5'd0) opa = 64'd0;
    else if (rf_fwd_vld_r && rf_fwd_addr_r == rs1) opa = rf_fwd_data_r;
    else if (!rf_vld_r[rs1]) opa = (rs1 == REG_SP) ? sp_init_r : 64'd0;
    else opa = rf_rdata_a_r;
    if (rb_sel == 5'd0) opb = 64'd0;
    else if (rf_fwd_vld_r && rf_fwd_addr_r == rb_sel) opb = rf_fwd_data_r;
    else if (!rf_vld_r[rb_sel]) opb = (rb_sel == REG_SP) ? sp_init_r : 64'd0;
    else opb = rf_rdata_b_r;
  end

  // csr read: trap csrs live in flops
  always_comb begin
    ca_special = 1'b1;
    if (ca_idx == IDX_MSTATUS) csr_old = mstatus_r;
    else if (ca_idx == IDX_MTVEC) csr_old = mtvec_r;
    else if (ca_idx == IDX_MEPC) csr_old = mepc_r;
    else if (ca_idx == IDX_MCAUSE) csr_old = mcause_r;
    else if (ca_idx == IDX_MTVAL) csr_old = mtval_r;
    else begin
      ca_special = 1'b0;
      if (csr_fwd_vld_r && csr_fwd_idx_r == ca_idx) csr_old = csr_fwd_data_r;
      else csr_old = csr_rdata_r;
    end
  end

  // execute
  always_comb begin
    logic [63:0] immi, immu, immj, immb, imms, src2, addsub, alu, pc4, tgt, csr_src;
    logic [63:0] ld;
    logic [5:0]  sh;
    logic        alt, sub, illegal, taken, w32, csr_we_any;
    res           = '0;
    rf_we         = 1'b0;
    rf_wa         = rd;
    rf_wd         = 64'd0;
    csr_wr        = 1'b0;
    csr_new       = 64'd0;
    trap_en       = 1'b0;
    trap_code     = CAUSE_INSN_MISALIGNED;
    trap_val      = 64'd0;
    mret_en       = 1'b0;
    illegal       = 1'b0;
    taken         = 1'b0;
    pc_nxt        = pc_r;
    pend_kind_nxt = pend_kind_r;
    pend_dest_nxt = pend_dest_r;
    pend_sz_nxt   = pend_sz_r;
    pend_addr_nxt = pend_addr_r;
    ld            = 64'd0;
    pc4  = pc_r + 64'd4;
    immi = {{52{ins[31]}}, ins[31:20]};
    immu = {{32{ins[31]}}, ins[31:12], 12'd0};
    immj = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    immb = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imms = {{52{ins[31]}}, ins[31:25], ins[11:7]};
    // alu
    w32  = (op == OPC_OPIMM32) || (op == OPC_OP32);
    src2 = (op == OPC_OP || op == OPC_OP32) ? opb : immi;
    sub  = (op == OPC_OP || op == OPC_OP32) && f7 == 7'h20 && f3 == 3'd0;
    if (op == OPC_OPIMM) alt = (f3 == 3'd5) && ins[31:26] == 6'h10;
    else if (op == OPC_OPIMM32) alt = (f3 != 3'd0) && f7 == 7'h20;
    else alt = (f7 == 7'h20);
    addsub = sub ? (opa - src2) : (opa + src2);
    sh     = w32 ? {1'b0, src2[4:0]} : src2[5:0];
    case (f3)
      3'd0: alu = addsub;
      3'd1: alu = w32 ? {32'd0, opa[31:0] << sh[4:0]} : opa << sh;
      3'd2: alu = {63'd0, $signed(opa) < $signed(src2)};
      3'd3: alu = {63'd0, opa < src2};
      3'd4: alu = opa ^ src2;
      3'd5: begin
        if (w32) alu = alt ? {32'd0, 32'($signed(opa[31:0]) >>> sh[4:0])}
                           : {32'd0, opa[31:0] >> sh[4:0]};
        else alu = alt ? 64'($signed(opa) >>> sh) : opa >> sh;
      end
      3'd6: alu = opa | src2;
      default: alu = opa & src2;
    endcase
    if (w32) alu = {{32{alu[31]}}, alu[31:0]};
    tgt = 64'd0;
    csr_src = f3[2] ? {59'd0, rs1} : opa;
    csr_we_any = (f3[1:0] == 2'd1) || (rs1 != 5'd0);

    case (s1_r.kind)
      KIND_INSN: begin
        if (pend_kind_r == REQ_NONE) begin
          if (pc_r[1:0] != 2'd0) begin
            trap_en = 1'b1; trap_code = CAUSE_INSN_MISALIGNED; trap_val = pc_r;
          end else begin
            case (op)
              OPC_LUI: begin
                rf_we = 1'b1; rf_wd = immu; pc_nxt = pc4;
              end
              OPC_AUIPC: begin
                rf_we = 1'b1; rf_wd = pc_r + immu; pc_nxt = pc4;
              end
              OPC_JAL: begin
                tgt = pc_r + immj;
                if (tgt[1:0] != 2'd0) begin
                  trap_en = 1'b1; trap_code = CAUSE_INSN_MISALIGNED; trap_val = tgt;
                end else begin
                  rf_we = 1'b1; rf_wd = pc4; pc_nxt = tgt;
                end
              end
              OPC_JALR: begin
                tgt = (opa + immi) & ~64'd1;
                if (f3 != 3'd0) illegal = 1'b1;
                else if (tgt[1:0] != 2'd0) begin
                  trap_en = 1'b1; trap_code = CAUSE_INSN_MISALIGNED; trap_val = tgt;
                end else begin
                  rf_we = 1'b1; rf_wd = pc4; pc_nxt = tgt;
                end
              end
              OPC_BRANCH: begin
                tgt = pc_r + immb;
                case (f3)
                  3'd0: taken = (opa == opb);
                  3'd1: taken = (opa != opb);
                  3'd4: taken = $signed(opa) < $signed(opb);
                  3'd5: taken = $signed(opa) >= $signed(opb);
                  3'd6: taken = opa < opb;
                  3'd7: taken = opa >= opb;
                  default: illegal = 1'b1;
                endcase
                if (!illegal) begin
                  if (!taken) pc_nxt = pc4;
                  else if (tgt[1:0] != 2'd0) begin
                    trap_en = 1'b1; trap_code = CAUSE_INSN_MISALIGNED; trap_val = tgt;
                  end else pc_nxt = tgt;
                end
              end
              OPC_LOAD: begin
                if (f3 == 3'd7) illegal = 1'b1;
                else begin
                  res.mem_request = REQ_LOAD;
                  res.mem_address = opa + immi;
                  res.mem_size    = f3[1:0];
                  pend_kind_nxt   = REQ_LOAD;
                  pend_dest_nxt   = rd;
                  pend_sz_nxt     = f3;
                  pend_addr_nxt   = opa + immi;
                end
              end
              OPC_STORE: begin
                if (f3[2]) illegal = 1'b1;
                else begin
                  res.mem_request = REQ_STORE;
                  res.mem_address = opa + imms;
                  res.mem_size    = f3[1:0];
                  res.store_data  = opb;
                  pend_kind_nxt   = REQ_STORE;
                  pend_dest_nxt   = 5'd0;
                  pend_sz_nxt     = f3;
                  pend_addr_nxt   = opa + imms;
                end
              end
              OPC_OPIMM: begin
                if (f3 == 3'd1) illegal = (ins[31:26] != 6'd0);
                else if (f3 == 3'd5) illegal = (ins[31:26] != 6'd0) && (ins[31:26] != 6'h10);
                if (!illegal) begin
                  rf_we = 1'b1; rf_wd = alu; pc_nxt = pc4;
                end
              end
              OPC_OPIMM32, OPC_OP32: begin
                if (!(op == OPC_OPIMM32 && f3 == 3'd0)) begin
                  if (f7 != 7'd0 && f7 != 7'h20) illegal = 1'b1;
                  else if (!(f3 == 3'd0 || (f3 == 3'd1 && !alt) || f3 == 3'd5)) illegal = 1'b1;
                end
                if (!illegal) begin
                  rf_we = 1'b1; rf_wd = alu; pc_nxt = pc4;
                end
              end
              OPC_OP: begin
                if (f7 != 7'd0 && f7 != 7'h20) illegal = 1'b1;
                else if (alt && f3 != 3'd0 && f3 != 3'd5) illegal = 1'b1;
                if (!illegal) begin
                  rf_we = 1'b1; rf_wd = alu; pc_nxt = pc4;
                end
              end
              OPC_FENCE: pc_nxt = pc4;
              OPC_SYSTEM: begin
                if (f3 == 3'd0) begin
                  if (rd != 5'd0 || rs1 != 5'd0) illegal = 1'b1;
                  else if (ins[31:20] == SYS_ECALL) begin
                    res.ecall_request  = 1'b1;
                    res.syscall_number = opb;
                    pc_nxt = pc4;
                  end else if (ins[31:20] == SYS_EBREAK) begin
                    trap_en = 1'b1; trap_code = CAUSE_BREAKPOINT; trap_val = pc_r;
                  end else if (ins[31:20] == SYS_MRET) begin
                    mret_en = 1'b1;
                    pc_nxt  = mepc_r & ~64'd3;
                  end else illegal = 1'b1;
                end else if (f3 == 3'd4) begin
                  illegal = 1'b1;
                end else if (csr_we_any && ins[31:30] == 2'b11) begin
                  illegal = 1'b1;
                end else begin
                  csr_wr = csr_we_any;
                  case (f3[1:0])
                    2'd1: csr_new = csr_src;
                    2'd2: csr_new = csr_old | csr_src;
                    default: csr_new = csr_old & ~csr_src;
                  endcase
                  rf_we = 1'b1; rf_wd = csr_old; pc_nxt = pc4;
                end
              end
              default: illegal = 1'b1;
            endcase
          end
        end
      end
      KIND_FETCH_FAULT: begin
        if (pend_kind_r == REQ_NONE) begin
          trap_en = 1'b1; trap_code = CAUSE_FETCH_FAULT; trap_val = pc_r;
        end
      end
      default: begin
        // memory response matching the pending request
        if (s1_r.kind == pend_kind_r) begin
          pend_kind_nxt = REQ_NONE;
          if (s1_r.mem_fault) begin
            trap_en   = 1'b1;
            trap_code = (s1_r.kind == KIND_LOAD_RSP) ? CAUSE_LOAD_FAULT : CAUSE_STORE_FAULT;
            trap_val  = pend_addr_r;
          end else begin
            if (s1_r.kind == KIND_LOAD_RSP) begin
              case (pend_sz_r[1:0])
                2'd0: ld = pend_sz_r[2] ? {56'd0, s1_r.mem_data[7:0]}
                                        : {{56{s1_r.mem_data[7]}}, s1_r.mem_data[7:0]};
                2'd1: ld = pend_sz_r[2] ? {48'd0, s1_r.mem_data[15:0]}
                                        : {{48{s1_r.mem_data[15]}}, s1_r.mem_data[15:0]};
                2'd2: ld = pend_sz_r[2] ? {32'd0, s1_r.mem_data[31:0]}
                                        : {{32{s1_r.mem_data[31]}}, s1_r.mem_data[31:0]};
                default: ld = s1_r.mem_data;
              endcase
              rf_we = 1'b1; rf_wa = pend_dest_r; rf_wd = ld;
            end
            pc_nxt = pc4;
          end
        end
      end
    endcase

    if (illegal) begin
      trap_en = 1'b1; trap_code = CAUSE_ILLEGAL; trap_val = {32'd0, ins};
    end
    if (trap_en) begin
      rf_we  = 1'b0;
      csr_wr = 1'b0;
      pc_nxt = mtvec_r & ~64'd3;
      res.trap_taken = 1'b1;
      res.trap_cause = trap_code;
    end
    if (rf_wa == 5'd0) rf_we = 1'b0;
    res.fetch_pc = pc_nxt;
  end

  // pipeline and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (s1_adv) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s1_r <= in_data;
    if (s1_adv) out_r <= res;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= START_PC_RST;
      sp_init_r     <= SP_INIT_RST;
      rf_vld_r      <= '0;
      pend_kind_r   <= REQ_NONE;
      pend_dest_r   <= '0;
      pend_sz_r     <= '0;
      pend_addr_r   <= '0;
      mstatus_r     <= '0;
      mtvec_r       <= '0;
      mepc_r        <= '0;
      mcause_r      <= '0;
      mtval_r       <= '0;
      rf_fwd_vld_r  <= 1'b0;
      csr_fwd_vld_r <= 1'b0;
      clr_active_r  <= 1'b1;
      clr_cnt_r     <= '0;
    end else begin
      // csr memory clearing pass
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_LAST) clr_active_r <= 1'b0;
      end
      if (s1_adv) begin
        pc_r        <= pc_nxt;
        pend_kind_r <= pend_kind_nxt;
        pend_dest_r <= pend_dest_nxt;
        pend_sz_r   <= pend_sz_nxt;
        pend_addr_r <= pend_addr_nxt;
        rf_fwd_vld_r <= rf_we;
        if (rf_we) begin
          rf_vld_r[rf_wa] <= 1'b1;
          rf_fwd_addr_r   <= rf_wa;
          rf_fwd_data_r   <= rf_wd;
        end
        csr_fwd_vld_r <= csr_mem_we;
        if (csr_mem_we) begin
          csr_fwd_idx_r  <= ca_idx;
          csr_fwd_data_r <= csr_new;
        end
        if (trap_en) begin
          mepc_r    <= pc_r;
          mcause_r  <= {61'd0, trap_code};
          mtval_r   <= trap_val;
          mstatus_r <= {mstatus_r[63:13], 2'b11, mstatus_r[10:8], mstatus_r[3],
                        mstatus_r[6:4], 1'b0, mstatus_r[2:0]};
        end else if (mret_en) begin
          mstatus_r <= {mstatus_r[63:13], 2'b11, mstatus_r[10:8], 1'b1,
                        mstatus_r[6:4], mstatus_r[7], mstatus_r[2:0]};
        end else if (csr_wr && ca_special) begin
          if (ca_idx == IDX_MSTATUS) mstatus_r <= csr_new;
          else if (ca_idx == IDX_MTVEC) mtvec_r <= csr_new;
          else if (ca_idx == IDX_MEPC) mepc_r <= csr_new;
          else if (ca_idx == IDX_MCAUSE) mcause_r <= csr_new;
          else mtval_r <= csr_new;
        end
      end
      // configuration transfer
      if (cfg_xfer) begin
        if (cfg_index == CFG_START_PC) pc_r <= cfg_data;
        else begin
          sp_init_r          <= cfg_data;
          rf_vld_r[REG_SP]   <= 1'b0;
          rf_fwd_vld_r       <= 1'b0;
        end
      end
    end
  end

  // no item enters while the csr memory is cleared
  a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_ready)
    else $error("item accepted during csr clearing pass");

  // x0 is never written
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && rf_we) |-> rf_wa != 5'd0)
    else $error("write to x0");

  // a memory request leaves a pending access behind
  a_req_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res.mem_request != REQ_NONE) |=> pend_kind_r != REQ_NONE)
    else $error("memory request without pending state");

  // a trap result targets an aligned vector
  a_trap_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.trap_taken) |-> out_r.fetch_pc[1:0] == 2'd0)
    else $error("trap to unaligned vector");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the rv64i execute unit: directed table, random programs, predictor
`timescale 1ns / 1ps

module testbench;
  import rv64eu_pkg::*;

  localparam int unsigned CSR_N      = CSR_ENTRIES_DFLT;
  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned RAND_ITEMS = 1530;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [63:0] cfg_data;

  rv64i_execute_unit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // architectural state mirrored by the predictor
  logic [63:0] arch_x [32];
  logic [63:0] arch_pc;
  logic [63:0] arch_csr [CSR_N];
  logic [1:0]  pend_kind;
  logic [4:0]  pend_dest;
  logic [2:0]  pend_fmt;
  logic [63:0] pend_addr;
  out_item_t   res;

  out_item_t   results_due [$];
  int unsigned errors;
  int unsigned n_items, n_traps, n_loads, n_stores, n_ecalls, n_cfg;
  int unsigned send_idle_pct, recv_stall_pct;

  function automatic logic [63:0] sx32(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic int unsigned csr_idx(logic [63:0] a);
    return int'(a & (CSR_N - 1));
  endfunction

  function automatic void write_x(logic [4:0] r, logic [63:0] v);
    if (r != 5'd0) arch_x[r] = v;
  endfunction

  function automatic void trap(logic [2:0] code, logic [63:0] tval);
    logic [63:0] st;
    arch_csr[csr_idx(CSR_MEPC)]   = arch_pc;
    arch_csr[csr_idx(CSR_MCAUSE)] = 64'(code);
    arch_csr[csr_idx(CSR_MTVAL)]  = tval;
    st = arch_csr[csr_idx(CSR_MSTATUS)];
    st[7] = st[3];
    st[3] = 1'b0;
    st[12:11] = 2'b11;
    arch_csr[csr_idx(CSR_MSTATUS)] = st;
    arch_pc = arch_csr[csr_idx(CSR_MTVEC)] & ~64'd3;
    res.trap_taken = 1'b1;
    res.trap_cause = code;
  endfunction

  // 64-bit alu; ok cleared for undefined funct3/alt pairs
  function automatic void alu64(logic [2:0] f3, bit alt, logic [63:0] a, logic [63:0] b,
                                output bit ok, output logic [63:0] r);
    ok = !(alt && f3 != 3'd0 && f3 != 3'd5);
    case (f3)
      3'd0: r = alt ? a - b : a + b;
      3'd1: r = a << b[5:0];
      3'd2: r = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
      3'd3: r = (a < b) ? 64'd1 : 64'd0;
      3'd4: r = a ^ b;
      3'd5: r = alt ? 64'($signed(a) >>> b[5:0]) : a >> b[5:0];
      3'd6: r = a | b;
      default: r = a & b;
    endcase
  endfunction

  function automatic void alu32(logic [2:0] f3, bit alt, logic [63:0] a, logic [63:0] b,
                                output bit ok, output logic [63:0] r);
    logic [31:0] lo;
    ok = 1'b1;
    r = '0;
    lo = a[31:0];
    if (f3 == 3'd0) r = sx32(alt ? a - b : a + b);
    else if (f3 == 3'd1 && !alt) r = sx32(a << b[4:0]);
    else if (f3 == 3'd5) r = alt ? sx32(64'($signed(lo) >>> b[4:0])) : sx32(64'(lo >> b[4:0]));
    else ok = 1'b0;
  endfunction

  function automatic void branch_to(bit taken, logic [63:0] tgt);
    if (!taken) arch_pc = arch_pc + 64'd4;
    else if (tgt[1:0] != 2'd0) trap(CAUSE_INSN_MISALIGNED, tgt);
    else arch_pc = tgt;
  endfunction

  function automatic void exec_insn(logic [31:0] ins);
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd, rs1;
    logic [63:0] a, b, immi, pc, r, tgt, old, src, st;
    logic [11:0] ca;
    bit ok, wr;
    op = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25];
    rd = ins[11:7]; rs1 = ins[19:15];
    a = arch_x[rs1]; b = arch_x[ins[24:20]];
    immi = {{52{ins[31]}}, ins[31:20]};
    pc = arch_pc;
    ok = 1'b1;
    r = '0;
    case (op)
      OPC_LUI: begin
        write_x(rd, {{32{ins[31]}}, ins[31:12], 12'd0}); arch_pc = pc + 64'd4;
      end
      OPC_AUIPC: begin
        write_x(rd, pc + {{32{ins[31]}}, ins[31:12], 12'd0}); arch_pc = pc + 64'd4;
      end
      OPC_JAL: begin
        tgt = pc + {{44{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
        if (tgt[1:0] != 2'd0) trap(CAUSE_INSN_MISALIGNED, tgt);
        else begin
          write_x(rd, pc + 64'd4); arch_pc = tgt;
        end
      end
      OPC_JALR: begin
        if (f3 != 3'd0) ok = 1'b0;
        else begin
          tgt = (a + immi) & ~64'd1;
          if (tgt[1:0] != 2'd0) trap(CAUSE_INSN_MISALIGNED, tgt);
          else begin
            write_x(rd, pc + 64'd4); arch_pc = tgt;
          end
        end
      end
      OPC_BRANCH: begin
        tgt = pc + {{52{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
        case (f3)
          3'd0: branch_to(a == b, tgt);
          3'd1: branch_to(a != b, tgt);
          3'd4: branch_to($signed(a) < $signed(b), tgt);
          3'd5: branch_to($signed(a) >= $signed(b), tgt);
          3'd6: branch_to(a < b, tgt);
          3'd7: branch_to(a >= b, tgt);
          default: ok = 1'b0;
        endcase
      end
      OPC_LOAD: begin
        if (f3 == 3'd7) ok = 1'b0;
        else begin
          res.mem_request = REQ_LOAD; res.mem_address = a + immi; res.mem_size = f3[1:0];
          pend_kind = REQ_LOAD; pend_dest = rd; pend_fmt = f3; pend_addr = a + immi;
        end
      end
      OPC_STORE: begin
        if (f3 > 3'd3) ok = 1'b0;
        else begin
          tgt = a + {{52{ins[31]}}, ins[31:25], ins[11:7]};
          res.mem_request = REQ_STORE; res.mem_address = tgt; res.mem_size = f3[1:0];
          res.store_data = b;
          pend_kind = REQ_STORE; pend_dest = 5'd0; pend_fmt = f3; pend_addr = tgt;
        end
      end
      OPC_OPIMM: begin
        if (f3 == 3'd1) begin
          alu64(3'd1, 1'b0, a, immi, ok, r);
          ok = ok && (ins[31:26] == 6'd0);
        end else if (f3 == 3'd5) begin
          alu64(3'd5, ins[31:26] == 6'h10, a, immi, ok, r);
          ok = ok && (ins[31:26] == 6'h00 || ins[31:26] == 6'h10);
        end else alu64(f3, 1'b0, a, immi, ok, r);
        if (ok) begin
          write_x(rd, r); arch_pc = pc + 64'd4;
        end
      end
      OPC_OPIMM32: begin
        if (f3 == 3'd0) alu32(3'd0, 1'b0, a, immi, ok, r);
        else begin
          alu32(f3, f7 == 7'h20, a, immi, ok, r);
          ok = ok && (f7 == 7'h00 || f7 == 7'h20);
        end
        if (ok) begin
          write_x(rd, r); arch_pc = pc + 64'd4;
        end
      end
      OPC_OP, OPC_OP32: begin
        if (op == OPC_OP) alu64(f3, f7 == 7'h20, a, b, ok, r);
        else alu32(f3, f7 == 7'h20, a, b, ok, r);
        ok = ok && (f7 == 7'h00 || f7 == 7'h20);
        if (ok) begin
          write_x(rd, r); arch_pc = pc + 64'd4;
        end
      end
      OPC_FENCE: arch_pc = pc + 64'd4;
      OPC_SYSTEM: begin
        if (f3 == 3'd0) begin
          if (rd != 5'd0 || rs1 != 5'd0) ok = 1'b0;
          else if (ins[31:20] == SYS_ECALL) begin
            res.ecall_request = 1'b1; res.syscall_number = arch_x[REG_SYSCALL];
            arch_pc = pc + 64'd4;
          end else if (ins[31:20] == SYS_EBREAK) trap(CAUSE_BREAKPOINT, pc);
          else if (ins[31:20] == SYS_MRET) begin
            st = arch_csr[csr_idx(CSR_MSTATUS)];
            arch_pc = arch_csr[csr_idx(CSR_MEPC)] & ~64'd3;
            st[3] = st[7];
            st[7] = 1'b1;
            st[12:11] = 2'b11;
            arch_csr[csr_idx(CSR_MSTATUS)] = st;
          end else ok = 1'b0;
        end else if (f3 == 3'd4) ok = 1'b0;
        else begin
          ca = ins[31:20];
          src = f3[2] ? 64'(rs1) : a;
          wr = (f3[1:0] == 2'd1) || (rs1 != 5'd0);
          if (wr && ca[11:10] == 2'b11) ok = 1'b0;
          else begin
            old = arch_csr[csr_idx(64'(ca))];
            if (wr) arch_csr[csr_idx(64'(ca))] = (f3[1:0] == 2'd1) ? src :
                                                 (f3[1:0] == 2'd2) ? (old | src) : (old & ~src);
            write_x(rd, old);
            arch_pc = pc + 64'd4;
          end
        end
      end
      default: ok = 1'b0;
    endcase
    if (!ok) trap(CAUSE_ILLEGAL, 64'(ins));
  endfunction

  // advance the mirrored core by one item and return the result it produces
  function automatic out_item_t predict_result(in_item_t it);
    logic [63:0] v;
    res = '0;
    if (it.kind == KIND_INSN) begin
      if (pend_kind == REQ_NONE) begin
        if (arch_pc[1:0] != 2'd0) trap(CAUSE_INSN_MISALIGNED, arch_pc);
        else exec_insn(it.instruction);
      end
    end else if (it.kind == KIND_FETCH_FAULT) begin
      if (pend_kind == REQ_NONE) trap(CAUSE_FETCH_FAULT, arch_pc);
    end else if (it.kind == pend_kind) begin
      pend_kind = REQ_NONE;
      if (it.mem_fault)
        trap(it.kind == KIND_LOAD_RSP ? CAUSE_LOAD_FAULT : CAUSE_STORE_FAULT, pend_addr);
      else begin
        if (it.kind == KIND_LOAD_RSP) begin
          case (pend_fmt[1:0])
            2'd0: v = pend_fmt[2] ? 64'(it.mem_data[7:0]) : {{56{it.mem_data[7]}}, it.mem_data[7:0]};
            2'd1: v = pend_fmt[2] ? 64'(it.mem_data[15:0]) :
                                    {{48{it.mem_data[15]}}, it.mem_data[15:0]};
            2'd2: v = pend_fmt[2] ? 64'(it.mem_data[31:0]) : sx32(it.mem_data);
            default: v = it.mem_data;
          endcase
          write_x(pend_dest, v);
        end
        arch_pc = arch_pc + 64'd4;
      end
    end
    res.fetch_pc = arch_pc;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // result checking
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) report_mismatch("unexpected result fetch_pc",
                                                   out_data.fetch_pc, '0);
      else begin
        want = results_due.pop_front();
        if (out_data.fetch_pc != want.fetch_pc)
          report_mismatch("fetch_pc", out_data.fetch_pc, want.fetch_pc);
        if (out_data.mem_request != want.mem_request)
          report_mismatch("mem_request", 64'(out_data.mem_request), 64'(want.mem_request));
        if (out_data.mem_address != want.mem_address)
          report_mismatch("mem_address", out_data.mem_address, want.mem_address);
        if (out_data.mem_size != want.mem_size)
          report_mismatch("mem_size", 64'(out_data.mem_size), 64'(want.mem_size));
        if (out_data.store_data != want.store_data)
          report_mismatch("store_data", out_data.store_data, want.store_data);
        if (out_data.trap_taken != want.trap_taken)
          report_mismatch("trap_taken", 64'(out_data.trap_taken), 64'(want.trap_taken));
        if (out_data.trap_cause != want.trap_cause)
          report_mismatch("trap_cause", 64'(out_data.trap_cause), 64'(want.trap_cause));
        if (out_data.ecall_request != want.ecall_request)
          report_mismatch("ecall_request", 64'(out_data.ecall_request),
                          64'(want.ecall_request));
        if (out_data.syscall_number != want.syscall_number)
          report_mismatch("syscall_number", out_data.syscall_number, want.syscall_number);
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  int unsigned quiet_cycles;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("testbench NOT OK");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  function automatic in_item_t mk_item(logic [1:0] k, logic [31:0] ins, logic [63:0] d,
                                       logic f);
    in_item_t it;
    it.kind = k; it.instruction = ins; it.mem_data = d; it.mem_fault = f;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // register numbers cluster low so results feed later instructions
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
  endfunction

  function automatic logic [31:0] rand_insn();
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [20:0] jimm;
    logic [11:0] imm, ca;
    logic [2:0]  sys_f3 [6];
    rd = pick_reg(); rs1 = pick_reg(); rs2 = pick_reg();
    f3 = 3'($urandom_range(7));
    f7 = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : ($urandom_range(1) ? 7'h20 : 7'h00);
    imm = 12'($urandom());
    jimm = 21'($urandom());
    if ($urandom_range(6) != 0) jimm[1] = 1'b0;
    sys_f3 = '{3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd7};
    case ($urandom_range(15))
      0: return {20'($urandom()), rd, OPC_LUI};
      1: return {20'($urandom()), rd, OPC_AUIPC};
      2: return {jimm[20], jimm[10:1], jimm[11], jimm[19:12], rd, OPC_JAL};
      3: begin
        if ($urandom_range(3) != 0) imm[1:0] = 2'd0;
        return {imm, rs1, ($urandom_range(9) == 0) ? f3 : 3'd0, rd, OPC_JALR};
      end
      4: return {jimm[12], jimm[10:5], rs2, rs1, f3, jimm[4:1], jimm[11], OPC_BRANCH};
      5, 6: return {imm, rs1, ($urandom_range(12) == 0) ? 3'd7 : 3'($urandom_range(6)), rd,
                    OPC_LOAD};
      7: return {imm[11:5], rs2, rs1, ($urandom_range(9) == 0) ? f3 : 3'($urandom_range(3)),
                 imm[4:0], OPC_STORE};
      8: begin
        if (f3 == 3'd1 || f3 == 3'd5) imm[11:6] = ($urandom_range(7) == 0) ? 6'($urandom()) :
                                                  (($urandom_range(1) && f3 == 3'd5) ? 6'h10 : 6'h00);
        return {imm, rs1, f3, rd, OPC_OPIMM};
      end
      9: return {f7, 5'($urandom()), rs1, f3, rd, OPC_OPIMM32};
      10: return {f7, rs2, rs1, f3, rd, OPC_OP};
      11: return {f7, rs2, rs1, f3, rd, OPC_OP32};
      12: return {12'($urandom()), 5'd0, 3'd0, 5'd0, OPC_FENCE};
      13: begin
        case ($urandom_range(3))
          0: ca = 12'(CSR_MSTATUS);
          1: ca = 12'(CSR_MTVEC);
          2: ca = {2'b11, 10'($urandom())};
          default: ca = ($urandom_range(1)) ? 12'(CSR_MEPC + $urandom_range(2)) : 12'($urandom());
        endcase
        return {ca, ($urandom_range(2) == 0) ? 5'd0 : rs1, sys_f3[$urandom_range(5)], rd,
                OPC_SYSTEM};
      end
      14: begin
        case ($urandom_range(4))
          0: return {SYS_ECALL, 13'd0, OPC_SYSTEM};
          1: return {SYS_EBREAK, 13'd0, OPC_SYSTEM};
          2: return {SYS_MRET, 13'd0, OPC_SYSTEM};
          3: return {12'($urandom()), rs1, 3'd0, rd, OPC_SYSTEM};
          default: return {12'($urandom()), rs1, 3'd4, rd, OPC_SYSTEM};
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // drive one input transfer and queue its result
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t p;
    p = predict_result(it);
    results_due.push_back(typed ? typed_res : p);
    n_items++;
    if (p.trap_taken) n_traps++;
    if (p.mem_request == REQ_LOAD) n_loads++;
    if (p.mem_request == REQ_STORE) n_stores++;
    if (p.ecall_request) n_ecalls++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_START_PC) arch_pc = val;
    else arch_x[REG_SP] = val;
    n_cfg++;
  endtask

  in_item_t    dir_items [$];
  bit          dir_typed [$];
  out_item_t   dir_res [$];

  task automatic add_row(in_item_t it, bit typed, out_item_t r);
    dir_items.push_back(it);
    dir_typed.push_back(typed);
    dir_res.push_back(r);
  endtask

  initial begin
    out_item_t   r, none;
    logic [63:0] pc_vals [4];
    logic [63:0] sp_vals [4];
    int unsigned idle_tab [4][2];
    int unsigned per_phase;
    in_item_t    it;
    int unsigned k;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_START_PC;
    cfg_data = '0;
    errors = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_items = 0; n_traps = 0; n_loads = 0; n_stores = 0; n_ecalls = 0; n_cfg = 0;
    none = '0;
    for (int i = 0; i < 32; i++) arch_x[i] = '0;
    for (int i = 0; i < CSR_N; i++) arch_csr[i] = '0;
    arch_x[REG_SP] = SP_INIT_RST;
    arch_pc = START_PC_RST;
    pend_kind = REQ_NONE; pend_dest = '0; pend_fmt = '0; pend_addr = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; the first rows have results readable straight from reset state
    r = '0; r.trap_taken = 1'b1; r.trap_cause = CAUSE_FETCH_FAULT;
    add_row(mk_item(KIND_FETCH_FAULT, '0, '0, 1'b0), 1'b1, r);
    r.trap_cause = CAUSE_ILLEGAL;
    add_row(mk_item(KIND_INSN, 32'h0000_0000, '1, 1'b1), 1'b1, r);
    r.trap_cause = CAUSE_BREAKPOINT;
    add_row(mk_item(KIND_INSN, {SYS_EBREAK, 13'd0, OPC_SYSTEM}, '0, 1'b0), 1'b1, r);
    r = '0; r.fetch_pc = 64'd4; r.ecall_request = 1'b1;
    add_row(mk_item(KIND_INSN, {SYS_ECALL, 13'd0, OPC_SYSTEM}, '0, 1'b0), 1'b1, r);
    // stray responses while nothing is pending
    r = '0; r.fetch_pc = 64'd4;
    add_row(mk_item(KIND_LOAD_RSP, '0, '1, 1'b0), 1'b1, r);
    add_row(mk_item(KIND_STORE_RSP, '0, '1, 1'b1), 1'b1, r);
    add_row(mk_item(KIND_INSN, 32'hFFFF_F8B7, '0, 1'b0), 1'b0, none);  // lui x17
    add_row(mk_item(KIND_INSN, {SYS_ECALL, 13'd0, OPC_SYSTEM}, '0, 1'b0), 1'b0, none);
    add_row(mk_item(KIND_INSN, 32'hFFF0_0093, '0, 1'b0), 1'b0, none);  // addi x1,x0,-1
    add_row(mk_item(KIND_INSN, 32'h0011_3023, '0, 1'b0), 1'b0, none);  // sd x1,0(x2)
    add_row(mk_item(KIND_INSN, 32'h0000_0013, '0, 1'b0), 1'b0, none);  // ignored, pending
    add_row(mk_item(KIND_FETCH_FAULT, '0, '0, 1'b0), 1'b0, none);      // ignored, pending
    add_row(mk_item(KIND_STORE_RSP, '0, '0, 1'b0), 1'b0, none);
    add_row(mk_item(KIND_INSN, 32'hFF81_3183, '0, 1'b0), 1'b0, none);  // ld x3,-8(x2)
    add_row(mk_item(KIND_LOAD_RSP, '0, '1, 1'b1), 1'b0, none);         // load fault
    add_row(mk_item(KIND_INSN, 32'h3050_9073, '0, 1'b0), 1'b0, none);  // csrrw mtvec,x1
    add_row(mk_item(KIND_INSN, 32'hFFFF_FFFF, '0, 1'b0), 1'b0, none);  // unknown opcode
    add_row(mk_item(KIND_INSN, {SYS_MRET, 13'd0, OPC_SYSTEM}, '0, 1'b0), 1'b0, none);
    add_row(mk_item(KIND_INSN, 32'hC000_9073, '0, 1'b0), 1'b0, none);  // write read-only csr
    add_row(mk_item(KIND_INSN, 32'h0020_006F, '0, 1'b0), 1'b0, none);  // jal misaligned
    add_row(mk_item(KIND_INSN, 32'h0030_02E7, '0, 1'b0), 1'b0, none);  // jalr misaligned
    add_row(mk_item(KIND_INSN, 32'h43F0_D313, '0, 1'b0), 1'b0, none);  // srai x6,x1,63
    add_row(mk_item(KIND_INSN, 32'h0000_000F, '0, 1'b0), 1'b0, none);  // fence
    add_row(mk_item(KIND_INSN, 32'hFF81_0183, '0, 1'b0), 1'b0, none);  // lb x3,-8(x2)
    add_row(mk_item(KIND_LOAD_RSP, '0, 64'h0000_0000_0000_0080, 1'b0), 1'b0, none);

    // reset values written back explicitly so the table starts from them
    write_cfg(CFG_START_PC, START_PC_RST);
    write_cfg(CFG_SP_INIT, SP_INIT_RST);
    foreach (dir_items[i]) send_item(dir_items[i], dir_typed[i], dir_res[i]);
    drain();

    // random programs over four traffic phases, settings changed between phases
    pc_vals = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'h0000_0000_8000_0000, rand64() & ~64'd3};
    sp_vals = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, rand64(), 64'h8000_0000_0000_0000};
    idle_tab = '{'{0, 0}, '{72, 0}, '{0, 72}, '{25, 25}};
    per_phase = RAND_ITEMS / 4;
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(CFG_START_PC, pc_vals[ph]);
      write_cfg(CFG_SP_INIT, sp_vals[ph]);
      send_idle_pct = idle_tab[ph][0];
      recv_stall_pct = idle_tab[ph][1];
      for (int n = 0; n < per_phase; n++) begin
        k = $urandom_range(99);
        if (pend_kind != REQ_NONE && k < 85)
          it = mk_item(pend_kind, $urandom(), rand64(), $urandom_range(6) == 0);
        else if (k < 4)
          it = mk_item(KIND_FETCH_FAULT, $urandom(), rand64(), 1'($urandom()));
        else if (k < 8)
          it = mk_item(2'($urandom_range(1, 2)), $urandom(), rand64(), 1'($urandom()));
        else
          it = mk_item(KIND_INSN, rand_insn(), rand64(), 1'($urandom()));
        send_item(it, 1'b0, none);
      end
      drain();
    end

    $display("covered %0d items: %0d traps, %0d loads, %0d stores, %0d ecalls",
             n_items, n_traps, n_loads, n_stores, n_ecalls);
    $display("%0d register writes across four traffic phases, %0d mismatches",
             n_cfg, errors);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
